### rtl/core/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and codes of the C string literal escaper: the command that
// the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package cse_pkg;

    // command kinds
    localparam logic [2:0] K_END  = 3'd0;  // terminating zero byte
    localparam logic [2:0] K_PASS = 3'd1;  // byte passes unchanged
    localparam logic [2:0] K_ESC  = 3'd2;  // backslash plus one letter
    localparam logic [2:0] K_OCT  = 3'd3;  // backslash plus octal digits
    localparam logic [2:0] K_U4   = 3'd4;  // backslash u plus four hex digits
    localparam logic [2:0] K_U8   = 3'd5;  // backslash U plus eight hex digits

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    localparam int CP_W  = 21;
    localparam int CNT_W = 4;

    typedef struct packed {
        logic [2:0]       kind;
        logic [CP_W-1:0]  value;  // byte, escape letter or code point
        logic [CNT_W-1:0] total;  // number of output bytes
    } t_cmd;

endpackage

### rtl/core/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Accepts input bytes, tracks UTF-8 sequences and classifies each byte into
// an output command for the queue.
// ----------------------------------------------------------------------------
module cse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_in_byte,
    output logic           o_stall,
    input  logic           i_full,
    output logic           o_push,
    output cse_pkg::t_cmd  o_cmd
);

    function automatic logic [7:0] esc_char(input logic [7:0] b);
        case (b)
            8'h5C:   esc_char = 8'h5C;
            8'h07:   esc_char = 8'h61;
            8'h08:   esc_char = 8'h62;
            8'h0C:   esc_char = 8'h66;
            8'h0A:   esc_char = 8'h6E;
            8'h0D:   esc_char = 8'h72;
            8'h09:   esc_char = 8'h74;
            8'h0B:   esc_char = 8'h76;
            8'h3F:   esc_char = 8'h3F;
            8'h22:   esc_char = 8'h22;
            default: esc_char = 8'h00;
        endcase
    endfunction

    function automatic logic is_pass(input logic [7:0] b);
        logic r;
        r = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
            ((b >= 8'h30) && (b <= 8'h39));
        case (b)
            8'h20, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26,
            8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2D, 8'h2B, 8'h3D, 8'h7C, 8'h7D,
            8'h7B, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h3A, 8'h2C, 8'h2E, 8'h2F,
            8'h3C, 8'h3E: r = 1'b1;
            default: r = r;
        endcase
        is_pass = r;
    endfunction

    logic [cse_pkg::CP_W-1:0] r_acc, n_acc;
    logic [1:0]               r_left, n_left;
    logic                     r_long, n_long;
    logic                     w_accept;
    logic [cse_pkg::CP_W-1:0] w_acc_cont;
    logic [7:0]               w_esc;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_esc    = esc_char(i_in_byte);
    assign w_acc_cont = {r_acc[cse_pkg::CP_W-7:0], i_in_byte[5:0]};

    always_comb begin
        n_acc       = r_acc;
        n_left      = r_left;
        n_long      = r_long;
        o_push      = 1'b0;
        o_cmd.kind  = cse_pkg::K_PASS;
        o_cmd.value = {13'd0, i_in_byte};
        o_cmd.total = 4'd1;
        if (w_accept) begin
            if (i_in_byte == 8'h00) begin
                n_acc      = '0;
                n_left     = 2'd0;
                n_long     = 1'b0;
                o_push     = 1'b1;
                o_cmd.kind = cse_pkg::K_END;
            end else if (r_left != 2'd0) begin
                n_acc  = w_acc_cont;
                n_left = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    n_acc       = '0;
                    n_long      = 1'b0;
                    o_push      = 1'b1;
                    o_cmd.value = w_acc_cont;
                    if (r_long) begin
                        o_cmd.kind  = cse_pkg::K_U8;
                        o_cmd.total = 4'd10;
                    end else begin
                        o_cmd.kind  = cse_pkg::K_U4;
                        o_cmd.total = 4'd6;
                    end
                end
            end else if (w_esc != 8'h00) begin
                o_push      = 1'b1;
                o_cmd.kind  = cse_pkg::K_ESC;
                o_cmd.value = {13'd0, w_esc};
                o_cmd.total = 4'd2;
            end else if (i_in_byte[7:5] == 3'b110) begin
                n_acc  = {16'd0, i_in_byte[4:0]};
                n_left = 2'd1;
                n_long = 1'b0;
            end else if (i_in_byte[7:4] == 4'b1110) begin
                n_acc  = {17'd0, i_in_byte[3:0]};
                n_left = 2'd2;
                n_long = 1'b0;
            end else if (i_in_byte[7:3] == 5'b11110) begin
                n_acc  = {18'd0, i_in_byte[2:0]};
                n_left = 2'd3;
                n_long = 1'b1;
            end else if (is_pass(i_in_byte)) begin
                o_push = 1'b1;
            end else begin
                o_push     = 1'b1;
                o_cmd.kind = cse_pkg::K_OCT;
                if (i_in_byte >= 8'd64) begin
                    o_cmd.total = 4'd4;
                end else if (i_in_byte >= 8'd8) begin
                    o_cmd.total = 4'd3;
                end else begin
                    o_cmd.total = 4'd2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= 2'd0;
            r_long <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_left <= n_left;
            r_long <= n_long;
        end
    end

endmodule

### rtl/core/cse_fifo.sv
// ----------------------------------------------------------------------------
// cse_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cse_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cse_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output cse_pkg::t_cmd  o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cse_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Expands each queued command into output bytes, one per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module cse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cse_pkg::t_cmd  i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_string_end
);

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = cse_pkg::CH_ZERO + {4'd0, nib};
        end else begin
            hex_char = cse_pkg::CH_LOW_A + {4'd0, nib} - 8'd10;
        end
    endfunction

    logic [cse_pkg::CNT_W-1:0] r_idx;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_last, r_end;
    logic                      w_advance, w_last;
    logic [cse_pkg::CNT_W-1:0] w_pos;
    logic [31:0]               w_hex32;
    logic [2:0]                w_oct;
    logic [7:0]                w_byte;

    assign w_advance = !i_empty && (!r_valid || !i_stall);
    assign w_last    = (r_idx == i_cmd.total - 4'd1);
    assign w_pos     = i_cmd.total - 4'd1 - r_idx;
    assign w_hex32   = {11'd0, i_cmd.value};
    assign o_pop     = w_advance && w_last;

    always_comb begin
        case (w_pos[1:0])
            2'd0:    w_oct = i_cmd.value[2:0];
            2'd1:    w_oct = i_cmd.value[5:3];
            default: w_oct = {1'b0, i_cmd.value[7:6]};
        endcase
    end

    always_comb begin
        w_byte = cse_pkg::CH_BSLASH;
        case (i_cmd.kind)
            cse_pkg::K_END:  w_byte = 8'h00;
            cse_pkg::K_PASS: w_byte = i_cmd.value[7:0];
            cse_pkg::K_ESC: begin
                if (r_idx != '0) w_byte = i_cmd.value[7:0];
            end
            cse_pkg::K_OCT: begin
                if (r_idx != '0) w_byte = cse_pkg::CH_ZERO + {5'd0, w_oct};
            end
            cse_pkg::K_U4, cse_pkg::K_U8: begin
                if (r_idx == 4'd1) begin
                    w_byte = (i_cmd.kind == cse_pkg::K_U8) ? cse_pkg::CH_UP_U
                                                           : cse_pkg::CH_LOW_U;
                end else if (r_idx != '0) begin
                    w_byte = hex_char(w_hex32[{w_pos[2:0], 2'b00} +: 4]);
                end
            end
            default: w_byte = cse_pkg::CH_BSLASH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_byte <= w_byte;
            r_last <= w_last;
            r_end  <= (i_cmd.kind == cse_pkg::K_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? '0 : r_idx + 4'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_last;
    assign o_string_end = r_end;

endmodule

### rtl/core/c_string_literal_escaper_top.sv
// ----------------------------------------------------------------------------
// c_string_literal_escaper_top
// Turns a raw byte stream into the body of a C string literal.
// ----------------------------------------------------------------------------
// One input byte per transfer; each byte yields zero to ten output bytes.
// Backslash, quote, question mark and the control bytes BEL, BS, FF, LF, CR,
// HT and VT become two-byte backslash escapes; UTF-8 sequences are gathered
// and come out as \u plus four lowercase hex digits (two- and three-byte
// forms) or \U plus eight (four-byte form); letters, digits and common
// keyboard symbols pass unchanged; every other byte becomes a backslash plus
// its octal value without leading zeros. A zero byte drops any pending
// sequence and yields one zero byte flagged with string_end. run_last marks
// the last output byte of each input byte. The front end takes one input
// byte per cycle while the command queue (FIFO_DEPTH entries) has room; the
// back end drives one output byte per cycle while the output is not
// stalled, so the sustained input rate follows the average expansion of
// the text. An accepted byte is registered in the queue and then in the
// back end's output register before it leaves.
// ----------------------------------------------------------------------------
module c_string_literal_escaper_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    output logic       o_stall,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_end
);

    cse_pkg::t_cmd w_push_cmd, w_head_cmd;
    logic          w_push, w_pop, w_full, w_empty;

    // front: classify bytes, track UTF-8 sequences
    cse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .o_stall   (o_stall),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // queue: decouple classification from expansion
    cse_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back: expand commands into output bytes
    cse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_head_cmd),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

`ifndef NO_ASSERTIONS
    // the terminating byte is zero and closes its run
    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_end) |-> (o_out_byte == 8'h00 && o_run_last))
        else $error("string end byte malformed");

    // a command is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue overflow");

    // a command is never popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command queue underflow");

    // a completed pop ends a run on the next output byte
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_valid && o_run_last))
        else $error("run end not flagged");
`endif

endmodule

### bench/tb_c_string_literal_escaper_top.sv
// ----------------------------------------------------------------------------
// tb_c_string_literal_escaper_top
// Self-checking bench for the C string literal escaper.
// ----------------------------------------------------------------------------
// Feeds raw bytes over the valid/stall input channel and checks every output
// transfer against a behavioral escaper kept in the bench. A short table of
// hand-picked bytes runs first: the terminator, plain characters, every
// backslash escape, octal extremes, a stray continuation byte, two-, three-
// and four-byte UTF-8 sequences and a sequence cut short by the terminator.
// Some table rows carry their escaped text typed in; the rest are checked
// against the behavioral escaper. Random text follows: mostly well-formed
// characters and UTF-8 sequences, plus noise and broken sequences. Both
// channels idle at random, with stretches of full rate in between.
// ----------------------------------------------------------------------------
module tb_c_string_literal_escaper_top;

    localparam int BYTE_GOAL   = 430;     // input transfers before the drain
    localparam int DIR_ROWS    = 26;
    localparam int CYCLE_LIMIT = 400000;  // far above the slowest correct run
    localparam int MAX_SHOWN   = 10;

    // One byte of escaped text as it leaves the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } t_lit_byte;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_string_end;

    // Escaped text still owed by the block, oldest first.
    t_lit_byte  literal_due[$];

    // Output of one escaper step: the characters and whether they end the string.
    logic [7:0] step_chars[$];
    logic       step_end;

    // Escaper state: code point bits so far, continuation bytes to go, \U form.
    logic [cse_pkg::CP_W-1:0] cp_acc    = '0;
    logic [1:0]               cont_left = '0;
    logic                     long_form = 1'b0;

    t_lit_byte  due;
    int         stall_left     = 0;
    bit         rx_calm        = 1'b0;
    bit         tx_calm        = 1'b0;
    int         mismatch_count = 0;
    int         bytes_sent     = 0;
    int         cycle_count    = 0;

    c_string_literal_escaper_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_byte    (i_in_byte),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral escaper
    // ------------------------------------------------------------------------

    // Letters, digits and the keyboard symbols that stand for themselves.
    function automatic bit is_plain(input logic [7:0] b);
        case (b)
            " ", "~", "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "-",
            "+", "=", "|", "}", "{", "[", "]", ";", "'", ":", ",", ".", "/",
            "<", ">":
                return 1'b1;
            default:
                return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")
                    || (b >= "0" && b <= "9");
        endcase
    endfunction

    // Letter that follows the backslash in a two-byte escape, zero if none.
    function automatic logic [7:0] escape_letter(input logic [7:0] b);
        case (b)
            cse_pkg::CH_BSLASH: return cse_pkg::CH_BSLASH;
            8'h07:     return "a";
            8'h08:     return "b";
            8'h0C:     return "f";
            8'h0A:     return "n";
            8'h0D:     return "r";
            8'h09:     return "t";
            8'h0B:     return "v";
            "?":       return "?";
            "\"":      return "\"";
            default:   return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? cse_pkg::CH_ZERO + {4'd0, nib}
                             : cse_pkg::CH_LOW_A + {4'd0, nib} - 8'd10;
    endfunction

    // Advance the escaper by one input byte; leave its text in step_chars.
    task automatic escape_byte(input logic [7:0] b);
        logic [7:0]  esc;
        logic [31:0] word;
        int          digits;
        step_chars.delete();
        step_end = 1'b0;
        esc = escape_letter(b);
        if (b == 8'h00) begin
            // terminator: drop whatever sequence is pending
            cp_acc    = '0;
            cont_left = '0;
            long_form = 1'b0;
            step_chars.push_back(8'h00);
            step_end = 1'b1;
        end else if (cont_left != 2'd0) begin
            // any nonzero byte counts as a continuation here, top bits ignored
            cp_acc    = {cp_acc[cse_pkg::CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                word   = long_form ? {11'd0, cp_acc} : {16'd0, cp_acc[15:0]};
                digits = long_form ? 8 : 4;
                step_chars.push_back(cse_pkg::CH_BSLASH);
                step_chars.push_back(long_form ? cse_pkg::CH_UP_U : cse_pkg::CH_LOW_U);
                for (int i = digits - 1; i >= 0; i--)
                    step_chars.push_back(hex_char(word[4*i +: 4]));
                cp_acc    = '0;
                long_form = 1'b0;
            end
        end else if (esc != 8'h00) begin
            step_chars.push_back(cse_pkg::CH_BSLASH);
            step_chars.push_back(esc);
        end else if (b[7:5] == 3'b110) begin
            cp_acc    = {16'd0, b[4:0]};
            cont_left = 2'd1;
            long_form = 1'b0;
        end else if (b[7:4] == 4'b1110) begin
            cp_acc    = {17'd0, b[3:0]};
            cont_left = 2'd2;
            long_form = 1'b0;
        end else if (b[7:3] == 5'b11110) begin
            cp_acc    = {18'd0, b[2:0]};
            cont_left = 2'd3;
            long_form = 1'b1;
        end else if (is_plain(b)) begin
            step_chars.push_back(b);
        end else begin
            // octal without leading zeros
            step_chars.push_back(cse_pkg::CH_BSLASH);
            if (b >= 8'd64)
                step_chars.push_back(cse_pkg::CH_ZERO + {6'd0, b[7:6]});
            if (b >= 8'd8)
                step_chars.push_back(cse_pkg::CH_ZERO + {5'd0, b[5:3]});
            step_chars.push_back(cse_pkg::CH_ZERO + {5'd0, b[2:0]});
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Directed table. A nonzero len means the escaped text is typed in, right
    // aligned in txt; otherwise the behavioral escaper supplies it.
    task automatic dir_row(input int k, output logic [7:0] din, output int len,
                           output logic [31:0] txt);
        len = 0;
        txt = '0;
        case (k)
            0:  begin din = 8'h00; len = 1; end                  // end right after reset
            1:  begin din = 8'h41; len = 1; txt = "A"; end
            2:  begin din = 8'h5C; len = 2; txt = "\\\\"; end
            3:  begin din = 8'h22; len = 2; txt = "\\\""; end
            4:  begin din = 8'h3F; len = 2; txt = "\\?"; end
            5:  din = 8'h07;
            6:  din = 8'h08;
            7:  din = 8'h0C;
            8:  din = 8'h0A;
            9:  din = 8'h0D;
            10: din = 8'h09;
            11: din = 8'h0B;
            12: begin din = 8'h01; len = 2; txt = "\\1"; end     // shortest octal
            13: begin din = 8'hFF; len = 4; txt = "\\377"; end   // invalid lead byte
            14: din = 8'h80;                                     // stray continuation
            15: din = 8'hC3;                                     // two-byte sequence
            16: din = 8'hA9;
            17: din = 8'hE2;                                     // three-byte sequence
            18: din = 8'h82;
            19: din = 8'hAC;
            20: din = 8'hF7;                                     // largest four-byte lead,
            21: din = 8'hFF;                                     // then continuations with
            22: din = 8'hC0;                                     // odd top bits
            23: din = 8'h7F;
            24: din = 8'hE2;                                     // cut short by the end
            default: begin din = 8'h00; len = 1; end
        endcase
    endtask

    // Present one byte after a random gap, hold it until the transfer, then
    // record the escaped text that it owes.
    task automatic send_byte(input logic [7:0] b, input int typed_len = 0,
                             input logic [31:0] typed_txt = '0);
        int gap;
        int n;
        if ($urandom_range(0, 19) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : int'($urandom_range(0, 7));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        escape_byte(b);
        if (typed_len > 0) begin
            step_chars.delete();
            for (int i = 0; i < typed_len; i++)
                step_chars.push_back(typed_txt[8*(typed_len-1-i) +: 8]);
            step_end = (b == 8'h00);
        end
        n = step_chars.size();
        for (int i = 0; i < n; i++)
            literal_due.push_back({step_chars[i], i == n - 1, step_end && i == n - 1});
        bytes_sent++;
    endtask

    // Drop valid and hold off until every owed byte has come out.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (literal_due.size() != 0) @(posedge i_clk);
    endtask

    // One random piece of text: mostly well-formed characters and sequences
    // with random content, the rest noise and broken sequences.
    task automatic send_random_segment();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
            b = 8'($urandom_range(32, 126));
            send_byte(b);
        end else if (pick < 42) begin
            b = 8'($urandom_range(1, 31));
            send_byte(b);
        end else if (pick < 52) begin
            send_byte({3'b110, 5'($urandom)});
            send_byte({2'b10, 6'($urandom)});
        end else if (pick < 60) begin
            send_byte({4'b1110, 4'($urandom)});
            repeat (2) send_byte({2'b10, 6'($urandom)});
        end else if (pick < 67) begin
            send_byte({5'b11110, 3'($urandom)});
            repeat (3) send_byte({2'b10, 6'($urandom)});
        end else if (pick < 77) begin
            b = 8'($urandom_range(1, 255));
            send_byte(b);
        end else if (pick < 83) begin
            // sequence broken by the terminator
            b = 8'($urandom_range(8'hC0, 8'hF7));
            send_byte(b);
            if ($urandom_range(0, 1) == 1)
                send_byte({2'b10, 6'($urandom)});
            send_byte(8'h00);
        end else if (pick < 90) begin
            // lead byte followed by arbitrary nonzero bytes
            b = 8'($urandom_range(8'hC0, 8'hF7));
            send_byte(b);
            repeat (3) begin
                b = 8'($urandom_range(1, 255));
                send_byte(b);
            end
        end else begin
            send_byte(8'h00);
        end
    endtask

    initial begin
        logic [7:0]  din;
        int          len;
        logic [31:0] txt;
        bit          paused;
        paused = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            dir_row(k, din, len, txt);
            send_byte(din, len, txt);
        end
        hold_until_drained();

        while (bytes_sent < BYTE_GOAL) begin
            // hold the sender once mid-run until the output side runs dry
            if (!paused && bytes_sent > BYTE_GOAL / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            send_random_segment();
        end

        // drain, then watch a while longer for stray output
        i_valid <= 1'b0;
        while (literal_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: check each transfer, then draw the next stall
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (literal_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("cycle %0d: unexpected byte %02h last %0b end %0b",
                             cycle_count, o_out_byte, o_run_last, o_string_end);
            end else begin
                due = literal_due.pop_front();
                if (o_out_byte !== due.out_byte || o_run_last !== due.run_last
                        || o_string_end !== due.string_end) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("cycle %0d: want byte %02h last %0b end %0b, got %02h %0b %0b",
                                 cycle_count, due.out_byte, due.run_last, due.string_end,
                                 o_out_byte, o_run_last, o_string_end);
                end
            end
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
            stall_left = rx_calm ? 0 : int'($urandom_range(0, 7));
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: abort a run that hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
